// ===== hw/rtl/kwt_pkg.sv =====
// Shared widths, character codes and result status codes of the keyword trie.
package kwt_pkg;

  // Default sizing of the trie.
  localparam int unsigned NODE_COUNT_DEF   = 256;
  localparam int unsigned SYMBOL_COUNT_DEF = 27;

  // Fixed field widths.
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned STAT_W = 2;

  // Characters that bound the alphabet.
  localparam logic [CHAR_W-1:0] CH_LOW_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_Z   = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UNDERSC = 8'h5f;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADCHAR = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

endpackage

// ===== hw/rtl/keyword_trie_with_tag.sv =====
// Keyword trie with per-word tag: node row memory, walk sequencer and result register.
// Each character reads the current node's row, then walks it (following or allocating the
// child). A final character also reads the reached node's row to mark it or look it up,
// unless the key has failed, in which case the result comes straight from the walk. A new
// character is taken only once the previous one is through; in_stall is high meanwhile and
// while a result waits for a stalled output. After reset a clearing pass writes every
// row to zero, during which in_stall is high.
module keyword_trie_with_tag
  import kwt_pkg::*;
#(
  parameter int unsigned NODE_COUNT   = NODE_COUNT_DEF,
  parameter int unsigned SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [CHAR_W-1:0] in_ch,
  input  logic              in_last,
  input  logic [TAG_W-1:0]  in_tag_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [TAG_W-1:0]  out_tag_out
);

  localparam int unsigned NodeW     = $clog2(NODE_COUNT);
  localparam int unsigned FreeW     = NodeW + 1;
  localparam int unsigned SymW      = $clog2(SYMBOL_COUNT);
  localparam int unsigned ChildBits = SYMBOL_COUNT * NodeW;
  localparam int unsigned TagLsb    = ChildBits;
  localparam int unsigned MarkBit   = ChildBits + TAG_W;
  localparam int unsigned RowW      = ChildBits + TAG_W + 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_MARK  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  // Control registers.
  state_t            state_r, state_nxt;
  logic [NodeW-1:0]  clr_r, clr_nxt;
  logic [FreeW-1:0]  next_free_r, next_free_nxt;
  logic [NodeW-1:0]  cursor_r, cursor_nxt;
  logic [STAT_W-1:0] failed_r, failed_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Captured beat and result payload.
  logic              op_r;
  logic              last_r;
  logic [TAG_W-1:0]  tag_r;
  logic [SymW-1:0]   sym_r;
  logic              sym_ok_r;
  logic [STAT_W-1:0] pend_status_r, out_status_r;
  logic [TAG_W-1:0]  pend_tag_r, out_tag_r;

  // Node row memory: children, tag and word mark of one node per row.
  logic [RowW-1:0]   row_mem [NODE_COUNT];
  logic [RowW-1:0]   rdata_r;
  logic              mem_we, mem_re;
  logic [NodeW-1:0]  mem_waddr, mem_raddr;
  logic [RowW-1:0]   mem_wdata;

  // Result hand-off.
  logic              in_accept;
  logic              out_free;
  logic              res_vld;
  logic [STAT_W-1:0] res_status;
  logic [TAG_W-1:0]  res_tag;
  logic              out_load;
  logic              pend_load;

  // Symbol decode of the incoming character.
  logic [CHAR_W-1:0] ch_diff;
  logic              ch_sym_ok;
  logic [SymW-1:0]   ch_sym;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    ch_diff   = in_ch - CH_LOW_A;
    ch_sym_ok = (in_ch == CH_UNDERSC) ||
                ((in_ch >= CH_LOW_A) && (in_ch <= CH_LOW_Z) &&
                 (ch_diff < CHAR_W'(SYMBOL_COUNT - 1)));
    ch_sym    = (in_ch == CH_UNDERSC) ? SymW'(SYMBOL_COUNT - 1) : ch_diff[SymW-1:0];
  end

  // Capture the accepted beat.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= in_op;
      last_r   <= in_last;
      tag_r    <= in_tag_in;
      sym_r    <= ch_sym;
      sym_ok_r <= ch_sym_ok;
    end
  end

  // Synchronous memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= row_mem[mem_raddr];
    end
  end

  // Walk sequencer: read the cursor row, follow or allocate the child, then mark or look up.
  always_comb begin
    logic [SymW-1:0]   sym_sel;
    logic [NodeW-1:0]  child;
    logic [RowW-1:0]   row_mod;
    logic [STAT_W-1:0] fail_w;
    logic [NodeW-1:0]  cur_w;

    state_nxt     = state_r;
    clr_nxt       = clr_r;
    next_free_nxt = next_free_r;
    cursor_nxt    = cursor_r;
    failed_nxt    = failed_r;
    mem_we        = 1'b0;
    mem_waddr     = cursor_r;
    mem_wdata     = rdata_r;
    mem_re        = 1'b0;
    mem_raddr     = cursor_r;
    res_vld       = 1'b0;
    res_status    = STAT_OK;
    res_tag       = '0;
    sym_sel       = sym_ok_r ? sym_r : '0;
    child         = rdata_r[sym_sel*NodeW +: NodeW];
    row_mod       = rdata_r;
    fail_w        = failed_r;
    cur_w         = cursor_r;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == NodeW'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          mem_re    = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (failed_r == STAT_OK) begin
          if (!sym_ok_r) begin
            fail_w = STAT_BADCHAR;
          end else if (child != '0) begin
            cur_w = child;
          end else if (op_r) begin
            fail_w = STAT_MISS;
          end else if (next_free_r == FreeW'(NODE_COUNT)) begin
            fail_w = STAT_FULL;
          end else begin
            row_mod[sym_sel*NodeW +: NodeW] = next_free_r[NodeW-1:0];
            mem_we        = 1'b1;
            mem_waddr     = cursor_r;
            mem_wdata     = row_mod;
            cur_w         = next_free_r[NodeW-1:0];
            next_free_nxt = next_free_r + 1'b1;
          end
        end
        if (!last_r) begin
          cursor_nxt = cur_w;
          failed_nxt = fail_w;
          state_nxt  = S_IDLE;
        end else if (fail_w != STAT_OK) begin
          res_vld    = 1'b1;
          res_status = fail_w;
          cursor_nxt = '0;
          failed_nxt = STAT_OK;
        end else begin
          cursor_nxt = cur_w;
          mem_re     = 1'b1;
          mem_raddr  = cur_w;
          state_nxt  = S_MARK;
        end
      end
      S_MARK: begin
        res_vld = 1'b1;
        if (!op_r) begin
          row_mod[MarkBit]            = 1'b1;
          row_mod[TagLsb +: TAG_W]    = tag_r;
          mem_we                      = 1'b1;
          mem_waddr                   = cursor_r;
          mem_wdata                   = row_mod;
        end else begin
          res_status = rdata_r[MarkBit] ? STAT_OK : STAT_MISS;
          res_tag    = rdata_r[TagLsb +: TAG_W];
        end
        cursor_nxt = '0;
        failed_nxt = STAT_OK;
      end
      S_OUT: begin
        state_nxt = S_OUT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Route a finished result to the output register, or park it until that frees up.
    out_load  = 1'b0;
    pend_load = 1'b0;
    if (res_vld) begin
      if (out_free) begin
        out_load  = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        pend_load = 1'b1;
        state_nxt = S_OUT;
      end
    end else if ((state_r == S_OUT) && out_free) begin
      out_load  = 1'b1;
      state_nxt = S_IDLE;
    end

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      next_free_r <= FreeW'(1);
      cursor_r    <= '0;
      failed_r    <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      next_free_r <= next_free_nxt;
      cursor_r    <= cursor_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: parked copy and output register.
  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_status_r <= res_status;
      pend_tag_r    <= res_tag;
    end
    if (out_load) begin
      out_status_r <= res_vld ? res_status : pend_status_r;
      out_tag_r    <= res_vld ? res_tag : pend_tag_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_tag_out = out_tag_r;

`ifndef SYNTHESIS
  // A row is never read and written in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("row memory read and write collide on one address");

  // The allocation pointer stays between one and the pool size.
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_free_r != '0) && (next_free_r <= FreeW'(NODE_COUNT)))
    else $error("next free node out of range");

  // The cursor only ever points at an allocated node.
  a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cursor_r} < next_free_r)
    else $error("cursor points past the allocated nodes");

  // When a result beat appears the key state is already back at the root.
  a_key_restart: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ((cursor_r == '0) && (failed_r == STAT_OK)))
    else $error("key state not cleared at end of key");
`endif

endmodule

// ===== tb/kwt_tb_pkg.sv =====
`timescale 1ns / 100ps
// Operation codes shared by the keyword trie testbench's stimulus and checker.
package kwt_tb_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } trie_op_e;

endpackage

// ===== tb/kwt_result_check.sv =====
`timescale 1ns / 100ps
// Checker that follows the keyword trie's beats, walks its own trie and compares every result.
module kwt_result_check
  import kwt_pkg::*;
  import kwt_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_op,
  input  logic [CHAR_W-1:0] in_ch,
  input  logic              in_last,
  input  logic [TAG_W-1:0]  in_tag_in,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [STAT_W-1:0] out_status,
  input  logic [TAG_W-1:0]  out_tag_out,
  output int                fail_count,
  output int                awaited_count,
  output logic              pool_full
);

  localparam int NODES  = NODE_COUNT_DEF;
  localparam int SYMS   = SYMBOL_COUNT_DEF;
  localparam int NODE_W = $clog2(NODES);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  tag;
  } trie_result_t;

  // Shadow trie: child links, word marks and tags, plus the walk of the current key.
  logic [NODE_W-1:0] child_of [NODES*SYMS];
  logic              word_end [NODES];
  logic [TAG_W-1:0]  word_tag [NODES];
  int                next_node;
  logic [NODE_W-1:0] walk_node;
  logic [STAT_W-1:0] walk_fail;
  trie_result_t      awaited_results [$];

  always @(posedge clk) begin : monitor
    int           sym;
    int           slot;
    trie_op_e     op;
    trie_result_t res;
    trie_result_t want;
    bit           bad;

    if (!rst_n) begin
      for (int i = 0; i < NODES*SYMS; i++) child_of[i] = '0;
      for (int i = 0; i < NODES; i++) begin
        word_end[i] = 1'b0;
        word_tag[i] = '0;
      end
      next_node = 1;
      walk_node = '0;
      walk_fail = STAT_OK;
      fail_count = 0;
      awaited_results.delete();
    end else begin
      // An input beat advances the walk; the final character of a key yields one result.
      if (in_valid && !in_stall) begin
        op = trie_op_e'(in_op);
        if (walk_fail == STAT_OK) begin
          if (in_ch == CH_UNDERSC) begin
            sym = SYMS - 1;
          end else if (in_ch >= CH_LOW_A && in_ch <= CH_LOW_Z &&
                       int'(in_ch - CH_LOW_A) < SYMS - 1) begin
            sym = int'(in_ch - CH_LOW_A);
          end else begin
            sym = -1;
          end
          if (sym < 0) begin
            walk_fail = STAT_BADCHAR;
          end else begin
            slot = int'(walk_node) * SYMS + sym;
            if (child_of[slot] != '0) begin
              walk_node = child_of[slot];
            end else if (op == OP_SEARCH) begin
              walk_fail = STAT_MISS;
            end else if (next_node >= NODES) begin
              walk_fail = STAT_FULL;
            end else begin
              child_of[slot] = NODE_W'(next_node);
              walk_node = NODE_W'(next_node);
              next_node++;
            end
          end
        end
        if (in_last) begin
          res.tag = '0;
          if (walk_fail != STAT_OK) begin
            res.status = walk_fail;
          end else if (op == OP_INSERT) begin
            word_end[walk_node] = 1'b1;
            word_tag[walk_node] = in_tag_in;
            res.status = STAT_OK;
          end else begin
            res.status = word_end[walk_node] ? STAT_OK : STAT_MISS;
            res.tag = word_tag[walk_node];
          end
          awaited_results.push_back(res);
          walk_node = '0;
          walk_fail = STAT_OK;
        end
      end

      // A result beat is matched against the oldest prediction, field by field.
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none awaited: got status %0d tag %02h",
                   $time, out_status, out_tag_out);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          bad = 1'b0;
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, out_status);
            bad = 1'b1;
          end
          if (out_tag_out !== want.tag) begin
            $display("%0t: tag mismatch: expected %02h, got %02h",
                     $time, want.tag, out_tag_out);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
    end
    awaited_count = awaited_results.size();
    pool_full = (next_node >= NODES);
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the keyword trie testbench: clock, reset, key stimulus, result stalls and verdict.
module tb_top;
  import kwt_pkg::*;
  import kwt_tb_pkg::*;

  typedef struct packed {
    logic [3:0]              len;
    logic [7:0][CHAR_W-1:0]  chars;
  } trie_key_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_op;
  logic [CHAR_W-1:0] in_ch;
  logic              in_last;
  logic [TAG_W-1:0]  in_tag_in;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [TAG_W-1:0]  out_tag_out;

  int   fail_count;
  int   awaited_count;
  logic pool_full;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int sent_chars = 0;
  int phase_start;

  trie_key_t known_keys [$];

  always #2 clk = ~clk;

  keyword_trie_with_tag DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_ch       (in_ch),
    .in_last     (in_last),
    .in_tag_in   (in_tag_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_tag_out (out_tag_out)
  );

  kwt_result_check checker_inst (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_ch         (in_ch),
    .in_last       (in_last),
    .in_tag_in     (in_tag_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_tag_out   (out_tag_out),
    .fail_count    (fail_count),
    .awaited_count (awaited_count),
    .pool_full     (pool_full)
  );

  // Result side: random stalls, or a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= 150;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #1000000;
    $display("** keyword_trie_with_tag: FAILED **");
    $finish;
  end

  // One character beat, after an optional random gap; returns once it is accepted.
  task automatic send_char(trie_op_e op, logic [CHAR_W-1:0] c, logic last,
                           logic [TAG_W-1:0] tag);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_ch     <= c;
    in_last   <= last;
    in_tag_in <= tag;
    do @(posedge clk); while (in_stall);
    sent_chars++;
  endtask

  // A whole key; a mixed key flips the op of some characters before the last.
  task automatic send_key(trie_op_e op, trie_key_t k, logic [TAG_W-1:0] tag, bit mixed);
    trie_op_e char_op;
    for (int i = 0; i < k.len; i++) begin
      char_op = op;
      if (mixed && i != k.len - 1 && $urandom_range(1))
        char_op = (op == OP_INSERT) ? OP_SEARCH : OP_INSERT;
      send_char(char_op, k.chars[i], i == k.len - 1,
                (i == k.len - 1) ? tag : TAG_W'($urandom_range(255)));
    end
  endtask

  // Narrow letters (a, b, c, underscore) make keys share prefixes.
  function automatic logic [CHAR_W-1:0] random_letter(bit narrow);
    int idx;
    idx = narrow ? $urandom_range(3) : $urandom_range(SYMBOL_COUNT_DEF - 1);
    if (idx == SYMBOL_COUNT_DEF - 1 || (narrow && idx == 3)) return CH_UNDERSC;
    return CH_LOW_A + CHAR_W'(idx);
  endfunction

  // Mostly well-formed keys, searches often reusing inserted ones; some noise and broken keys.
  task automatic send_random_key(bit long_insert);
    trie_key_t k;
    trie_op_e  op;
    int        pick;
    bit        narrow;
    k = '0;
    op = $urandom_range(1) ? OP_SEARCH : OP_INSERT;
    pick = $urandom_range(99);
    if (long_insert) begin
      op = OP_INSERT;
      k.len = 4'd8;
      for (int i = 0; i < 8; i++) k.chars[i] = random_letter(1'b0);
    end else if (pick < 10) begin
      k.len = 4'($urandom_range(4, 1));
      for (int i = 0; i < k.len; i++) k.chars[i] = CHAR_W'($urandom_range(255));
    end else if (op == OP_SEARCH && known_keys.size() > 0 && pick < 65) begin
      k = known_keys[$urandom_range(known_keys.size() - 1)];
      // A prefix usually lands on a node that is not a word; an extension usually misses.
      if ($urandom_range(4) == 0 && k.len > 1) begin
        k.len = k.len - 4'd1;
      end else if ($urandom_range(4) == 0 && k.len < 8) begin
        k.chars[k.len] = random_letter(1'b1);
        k.len = k.len + 4'd1;
      end
    end else begin
      narrow = $urandom_range(99) < 70;
      k.len = 4'($urandom_range(6, 1));
      for (int i = 0; i < k.len; i++) k.chars[i] = random_letter(narrow);
      if ($urandom_range(19) == 0)
        k.chars[$urandom_range(k.len - 1)] = CHAR_W'($urandom_range(8'hff, 8'h7b));
    end
    if (op == OP_INSERT && pick >= 10 && known_keys.size() < 64) known_keys.push_back(k);
    send_key(op, k, TAG_W'($urandom_range(255)), $urandom_range(19) == 0);
  endtask

  task automatic run_phase(int n_chars);
    phase_start = sent_chars;
    while (sent_chars - phase_start < n_chars) send_random_key(1'b0);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_op     <= OP_INSERT;
    in_ch     <= '0;
    in_last   <= 1'b0;
    in_tag_in <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed keys: tag extremes, both ops, misses, bad bytes, a failure then more
    // characters, a mixed-op key and a tag overwrite.
    send_char(OP_INSERT, "a", 1'b1, 8'hff);
    send_char(OP_INSERT, "z", 1'b0, 8'h00);
    send_char(OP_INSERT, "_", 1'b1, 8'h00);
    send_char(OP_INSERT, "a", 1'b0, 8'h11);
    send_char(OP_INSERT, "b", 1'b1, 8'h5a);
    send_char(OP_SEARCH, "a", 1'b0, 8'h00);
    send_char(OP_SEARCH, "b", 1'b1, 8'h00);
    send_char(OP_SEARCH, "z", 1'b1, 8'h00);
    send_char(OP_SEARCH, "q", 1'b1, 8'h00);
    send_char(OP_INSERT, 8'h00, 1'b0, 8'h77);
    send_char(OP_INSERT, "a", 1'b1, 8'h77);
    send_char(OP_SEARCH, 8'hff, 1'b1, 8'h00);
    send_char(OP_SEARCH, "a", 1'b0, 8'h00);
    send_char(OP_SEARCH, 8'h7b, 1'b0, 8'h00);
    send_char(OP_SEARCH, "b", 1'b1, 8'h00);
    send_char(OP_SEARCH, "x", 1'b0, 8'h00);
    send_char(OP_SEARCH, 8'h60, 1'b1, 8'h00);
    send_char(OP_SEARCH, "a", 1'b0, 8'h00);
    send_char(OP_INSERT, "c", 1'b1, 8'h3c);
    send_char(OP_SEARCH, "a", 1'b0, 8'h00);
    send_char(OP_SEARCH, "c", 1'b1, 8'h00);
    send_char(OP_INSERT, "a", 1'b1, 8'h01);
    send_char(OP_SEARCH, "a", 1'b1, 8'h00);

    // Random keys: no idling, then sender gaps.
    run_phase(40);
    idle_pct = 45;
    run_phase(40);

    // Long fresh inserts until the node pool runs dry.
    while (!pool_full && sent_chars < 2000) send_random_key(1'b1);

    // Receiver stalls, then both sides idling, with the pool exhausted.
    idle_pct = 0;
    stall_pct <= 45;
    run_phase(40);
    idle_pct = 36;
    stall_pct <= 36;
    run_phase(40);

    // Long receiver hold-off while keys keep coming, so the block backs up.
    idle_pct = 0;
    stall_pct <= 0;
    hold_requests <= hold_requests + 1;
    run_phase(30);

    in_valid <= 1'b0;
    wait (awaited_count == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** keyword_trie_with_tag: PASSED **");
    end else begin
      $display("** keyword_trie_with_tag: FAILED **");
    end
    $finish;
  end

endmodule

// ===== keyword_trie_with_tag.f =====
hw/rtl/kwt_pkg.sv
hw/rtl/keyword_trie_with_tag.sv
tb/kwt_tb_pkg.sv
tb/kwt_result_check.sv
tb/tb_top.sv
